FILE: sv/sri_pkg.sv
// ----------------------------------------------------------------------------
// Segment/rectangle intersection package
// Shared constants for the segment versus rectangle hit tester.
// ----------------------------------------------------------------------------
package sri_pkg;

  localparam int unsigned NUM_IN_FIELDS = 8;
  localparam int unsigned OUT_TDATA_W   = 8;
  localparam int unsigned HIT_BIT       = 0;
  localparam int unsigned PIPE_DEPTH    = 4;

endpackage : sri_pkg

FILE: sv/segment_rectangle_intersect_top.sv
// ----------------------------------------------------------------------------
// Segment/rectangle intersection top level
// Reports whether a line segment touches a filled axis-aligned rectangle.
// ----------------------------------------------------------------------------
// An input word passes stages 1, 2, 3 and the output register in turn.
// Throughput: one word per cycle; the four stages advance together and hold
// as a whole while the output register is full and out_tready is low.
// Reset: rst_n (synchronous, active low) clears all stage valid bits; the
// data registers are not reset.
module segment_rectangle_intersect_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y
  input  logic [sri_pkg::NUM_IN_FIELDS*COORD_BITS-1:0] in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hit, then zero padding
  output logic [sri_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sri_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;

  logic ce;

  logic signed [CB-1:0] sx, sy, ex, ey, ax, ay, bx, by;

  // Stage 1: captured segment and sorted rectangle.
  logic                 s1_valid_r;
  logic signed [CB-1:0] s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;
  logic signed [CB-1:0] s1_rx0_r, s1_rx1_r, s1_ry0_r, s1_ry1_r;

  // Stage 2: differences and bounding box reject.
  logic                 s2_valid_r;
  logic                 s2_miss_r;
  logic signed [DW-1:0] s2_dx_r, s2_dy_r, s2_px0_r, s2_px1_r, s2_py0_r, s2_py1_r;
  logic                 s2_miss_nxt;

  // Stage 3: partial products.
  logic                 s3_valid_r;
  logic                 s3_miss_r;
  logic signed [PW-1:0] s3_a0_r, s3_a1_r, s3_b0_r, s3_b1_r;

  // Stage 4: output register.
  logic                 out_valid_r;
  logic                 hit_r;
  logic                 hit_nxt;

  logic signed [XW-1:0] c0, c1, c2, c3;
  logic                 all_pos, all_neg;

  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  assign sx = in_tdata[0*CB +: CB];
  assign sy = in_tdata[1*CB +: CB];
  assign ex = in_tdata[2*CB +: CB];
  assign ey = in_tdata[3*CB +: CB];
  assign ax = in_tdata[4*CB +: CB];
  assign ay = in_tdata[5*CB +: CB];
  assign bx = in_tdata[6*CB +: CB];
  assign by = in_tdata[7*CB +: CB];

  assign s2_miss_nxt =
      ((s1_sx_r > s1_ex_r ? s1_sx_r : s1_ex_r) < s1_rx0_r) ||
      ((s1_sx_r < s1_ex_r ? s1_sx_r : s1_ex_r) > s1_rx1_r) ||
      ((s1_sy_r > s1_ey_r ? s1_sy_r : s1_ey_r) < s1_ry0_r) ||
      ((s1_sy_r < s1_ey_r ? s1_sy_r : s1_ey_r) > s1_ry1_r);

  assign c0 = {s3_a0_r[PW-1], s3_a0_r} - {s3_b0_r[PW-1], s3_b0_r};
  assign c1 = {s3_a0_r[PW-1], s3_a0_r} - {s3_b1_r[PW-1], s3_b1_r};
  assign c2 = {s3_a1_r[PW-1], s3_a1_r} - {s3_b1_r[PW-1], s3_b1_r};
  assign c3 = {s3_a1_r[PW-1], s3_a1_r} - {s3_b0_r[PW-1], s3_b0_r};

  assign all_pos = (c0 > 0) && (c1 > 0) && (c2 > 0) && (c3 > 0);
  assign all_neg = (c0 < 0) && (c1 < 0) && (c2 < 0) && (c3 < 0);
  assign hit_nxt = !s3_miss_r && !(all_pos || all_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_sx_r  <= sx;
      s1_sy_r  <= sy;
      s1_ex_r  <= ex;
      s1_ey_r  <= ey;
      s1_rx0_r <= (ax < bx) ? ax : bx;
      s1_rx1_r <= (ax < bx) ? bx : ax;
      s1_ry0_r <= (ay < by) ? ay : by;
      s1_ry1_r <= (ay < by) ? by : ay;

      s2_miss_r <= s2_miss_nxt;
      s2_dx_r   <= {s1_ex_r[CB-1], s1_ex_r} - {s1_sx_r[CB-1], s1_sx_r};
      s2_dy_r   <= {s1_ey_r[CB-1], s1_ey_r} - {s1_sy_r[CB-1], s1_sy_r};
      s2_px0_r  <= {s1_rx0_r[CB-1], s1_rx0_r} - {s1_sx_r[CB-1], s1_sx_r};
      s2_px1_r  <= {s1_rx1_r[CB-1], s1_rx1_r} - {s1_sx_r[CB-1], s1_sx_r};
      s2_py0_r  <= {s1_ry0_r[CB-1], s1_ry0_r} - {s1_sy_r[CB-1], s1_sy_r};
      s2_py1_r  <= {s1_ry1_r[CB-1], s1_ry1_r} - {s1_sy_r[CB-1], s1_sy_r};

      s3_miss_r <= s2_miss_r;
      s3_a0_r   <= PW'(s2_dx_r * s2_py0_r);
      s3_a1_r   <= PW'(s2_dx_r * s2_py1_r);
      s3_b0_r   <= PW'(s2_dy_r * s2_px0_r);
      s3_b1_r   <= PW'(s2_dy_r * s2_px1_r);

      hit_r <= hit_nxt;
    end
  end

  always_comb begin
    out_tdata          = '0;
    out_tdata[HIT_BIT] = hit_r;
  end
  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_miss_gives_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && s3_miss_r && ce |=> !out_tdata[HIT_BIT])
    else $error("bounding box reject produced a hit");

  a_bubble_stays_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    ce && !s3_valid_r |=> !out_tvalid)
    else $error("result word appeared from an empty stage");

  a_point_segment_in_box_hits: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !s3_miss_r && ce && s3_a0_r == '0 && s3_a1_r == '0 &&
    s3_b0_r == '0 && s3_b1_r == '0 |=> out_tdata[HIT_BIT])
    else $error("collinear word inside the box was reported as a miss");
`endif

endmodule : segment_rectangle_intersect_top
